// ===== hdl/cad_pkg.sv =====
// ----------------------------------------------------------------------------
// cad_pkg
// Types and constants shared by the gray stroke darkener pipeline.
// ----------------------------------------------------------------------------
package cad_pkg;

  localparam int COLOR_FRAC_BITS_DEF = 12;

  localparam int CW = 12;
  localparam int MW = 20;
  localparam int LW = 26;
  localparam int TW = 31;
  localparam int NW = 45;
  localparam int SW = 40;
  localparam int VW = 57;
  localparam int RW = 28;
  localparam int WW = 17;

  localparam logic [34:0] BLEND_TOP = 35'd88080384;
  localparam logic [21:0] RECIP_15 = 22'd2236963;
  localparam int RECIP_SHIFT = 25;
  localparam logic [WW-1:0] W_ONE = 17'd65536;

  typedef struct packed {
    logic [CW-1:0]        red_in;
    logic [CW-1:0]        green_in;
    logic [CW-1:0]        blue_in;
    logic signed [MW-1:0] matrix_a;
    logic signed [MW-1:0] matrix_b;
  } in_item_t;

  typedef struct packed {
    logic [CW-1:0] red_out;
    logic [CW-1:0] green_out;
    logic [CW-1:0] blue_out;
  } out_item_t;

  typedef struct packed {
    logic [2:0][CW-1:0] c;
    logic               apply;
    logic [2:0][CW-1:0] q;
    logic [2:0][NW-1:0] drem;
    logic [TW-1:0]      dvs;
    logic [VW-1:0]      srem;
    logic [RW-1:0]      root;
    logic               tiny;
  } cell_t;

endpackage

// ===== hdl/cad_stream_if.sv =====
// ----------------------------------------------------------------------------
// cad_stream_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface cad_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cad_gray_stroke_darkener_top.sv =====
// ----------------------------------------------------------------------------
// cad_gray_stroke_darkener_top
// Darkens neutral light grays and blends by the view expansion.
//
//   channel   dir  payload     handshake
//   item_i    in   in_item_t   valid/ready
//   result_o  out  out_item_t  valid/ready
//
// One item is accepted every cycle unless the result stalls; each passes two front stages,
// a row of 28 cells (one square root bit each, the lower twelve also one
// quotient bit per channel) and two blend stages.
// Reset clears only the valid bits of the stages.
// A stalled result halts the whole pipeline; it resumes without loss.
// ----------------------------------------------------------------------------
module cad_gray_stroke_darkener_top #(
  parameter int COLOR_FRAC_BITS = cad_pkg::COLOR_FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cad_stream_if.sink   item_i,
  cad_stream_if.source result_o
);
  import cad_pkg::*;

  localparam logic [39:0] FS = (40'd1 << COLOR_FRAC_BITS) - 40'd1;
  localparam logic [CW-1:0] MASK = FS[CW-1:0];

  logic      en;
  logic      vld [0:RW];
  cell_t     chain [0:RW];
  out_item_t res;
  logic      res_valid;

  assign en           = !res_valid || result_o.ready;
  assign item_i.ready = en;

  cad_front #(.COLOR_FRAC_BITS(COLOR_FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(item_i.valid), .item_i(item_i.data),
    .valid_o(vld[0]), .cell_o(chain[0])
  );

  for (genvar g = 0; g < RW; g++) begin : g_cell
    cad_cell #(.K(RW - 1 - g), .DIV_EN((RW - 1 - g) < CW)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .valid_i(vld[g]), .cell_i(chain[g]),
      .valid_o(vld[g+1]), .cell_o(chain[g+1])
    );
  end

  cad_blend #(.COLOR_FRAC_BITS(COLOR_FRAC_BITS)) u_blend (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vld[RW]), .cell_i(chain[RW]),
    .valid_o(res_valid), .item_o(res)
  );

  assign result_o.valid = res_valid;
  assign result_o.data  = res;

`ifndef ASSERT_OFF
  a_out_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> ((res.red_out & ~MASK) == '0) && ((res.green_out & ~MASK) == '0) &&
                  ((res.blue_out & ~MASK) == '0))
    else $error("result channel outside full scale");
  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld[RW] && chain[RW].apply) |-> (chain[RW].q[0] <= chain[RW].c[0]) &&
      (chain[RW].q[1] <= chain[RW].c[1]) && (chain[RW].q[2] <= chain[RW].c[2]))
    else $error("darkened channel above original");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(chain[RW]) && $stable(vld[RW]))
    else $error("row moved during a stall");
`endif

endmodule

// ===== hdl/cad_front.sv =====
// ----------------------------------------------------------------------------
// cad_front
// Luminance, chroma, gray test, target and the operands for the cell row.
// ----------------------------------------------------------------------------
module cad_front #(
  parameter int COLOR_FRAC_BITS = cad_pkg::COLOR_FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  cad_pkg::in_item_t item_i,
  output logic             valid_o,
  output cad_pkg::cell_t   cell_o
);
  import cad_pkg::*;

  localparam logic [39:0] FS = (40'd1 << COLOR_FRAC_BITS) - 40'd1;
  localparam logic [CW-1:0] MASK = FS[CW-1:0];
  localparam logic [39:0] CHROMA_MAX = 40'd14 * FS;
  localparam logic [39:0] LUM_LO = 40'd4800 * FS;
  localparam logic [39:0] LUM_HI = 40'd8600 * FS;
  localparam logic [39:0] LUM_MID = 40'd5000 * FS;
  localparam logic [39:0] T_BASE = 40'd48000 * FS;
  localparam logic [39:0] T_CAP = 40'd115200 * FS;

  logic               v0_q, v1_q;
  logic [2:0][CW-1:0] c0_d, c0_q, c1_q;
  logic [CW-1:0]      chroma_d, chroma_q;
  logic [LW-1:0]      lum_d, lum_q, lum1_q;
  logic [MW-1:0]      ma_d, ma_q, mb_d, mb_q;
  logic [CW-1:0]      mx, mn;
  logic [39:0]        lum_x, t_full, t_cap;
  logic               gray, apply_d, apply_q;
  logic [TW-1:0]      t32_q;
  logic [SW-1:0]      s_d, s_q;

  always_comb begin
    c0_d[0] = item_i.red_in & MASK;
    c0_d[1] = item_i.green_in & MASK;
    c0_d[2] = item_i.blue_in & MASK;
    mx = c0_d[0];
    mn = c0_d[0];
    for (int i = 1; i < 3; i++) begin
      if (c0_d[i] > mx) mx = c0_d[i];
      if (c0_d[i] < mn) mn = c0_d[i];
    end
    chroma_d = mx - mn;
    lum_d = LW'(26'd2126 * c0_d[0]) + LW'(26'd7152 * c0_d[1]) + LW'(26'd722 * c0_d[2]);
    ma_d = item_i.matrix_a[MW-1] ? MW'(~item_i.matrix_a + 1'b1) : MW'(item_i.matrix_a);
    mb_d = item_i.matrix_b[MW-1] ? MW'(~item_i.matrix_b + 1'b1) : MW'(item_i.matrix_b);
  end

  always_comb begin
    lum_x = {14'd0, lum_q};
    gray = (40'd100 * {28'd0, chroma_q} <= CHROMA_MAX) && (lum_x >= LUM_LO) &&
           (lum_x <= LUM_HI) && (lum_x > LUM_MID);
    t_full = T_BASE + 40'd21 * (lum_x - LUM_MID);
    t_cap = (t_full > T_CAP) ? T_CAP : t_full;
    apply_d = gray && (t_cap < {9'd0, lum_q, 5'd0});
    s_d = SW'({20'd0, ma_q} * {20'd0, ma_q}) + SW'({20'd0, mb_q} * {20'd0, mb_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c0_q     <= c0_d;
      chroma_q <= chroma_d;
      lum_q    <= lum_d;
      ma_q     <= ma_d;
      mb_q     <= mb_d;
      c1_q     <= c0_q;
      lum1_q   <= lum_q;
      apply_q  <= apply_d;
      t32_q    <= t_cap[TW-1:0];
      s_q      <= s_d;
    end
  end

  always_comb begin
    cell_o.c     = c1_q;
    cell_o.apply = apply_q;
    cell_o.q     = '0;
    for (int i = 0; i < 3; i++) begin
      cell_o.drem[i] = NW'({33'd0, c1_q[i]} * {14'd0, t32_q}) + {15'd0, lum1_q, 4'd0};
    end
    cell_o.dvs  = {lum1_q, 5'd0};
    cell_o.srem = {1'b0, s_q, 16'd0};
    cell_o.root = '0;
    cell_o.tiny = (s_q <= SW'(16));
  end

  assign valid_o = v1_q;

endmodule

// ===== hdl/cad_cell.sv =====
// ----------------------------------------------------------------------------
// cad_cell
// One cell of the row: one root bit and, low in the row, one quotient bit.
// ----------------------------------------------------------------------------
module cad_cell #(
  parameter int K      = 0,
  parameter bit DIV_EN = 1'b0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  cad_pkg::cell_t cell_i,
  output logic           valid_o,
  output cad_pkg::cell_t cell_o
);
  import cad_pkg::*;

  localparam int QK = (K < CW) ? K : 0;

  cell_t         cell_d, cell_q;
  logic          valid_q;
  logic [VW-1:0] trial;
  logic [NW-1:0] dd;

  always_comb begin
    cell_d = cell_i;
    trial = ({{(VW-RW){1'b0}}, cell_i.root} << (K + 1)) + (VW'(1) << (2 * K));
    if (cell_i.srem >= trial) begin
      cell_d.srem = cell_i.srem - trial;
      cell_d.root[K] = 1'b1;
    end
    dd = {{(NW-TW){1'b0}}, cell_i.dvs} << K;
    if (DIV_EN) begin
      for (int i = 0; i < 3; i++) begin
        if (cell_i.drem[i] >= dd) begin
          cell_d.drem[i] = cell_i.drem[i] - dd;
          cell_d.q[i][QK] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

// ===== hdl/cad_blend.sv =====
// ----------------------------------------------------------------------------
// cad_blend
// Blend weight from the expansion, then the mix of original and darkened.
// ----------------------------------------------------------------------------
module cad_blend #(
  parameter int COLOR_FRAC_BITS = cad_pkg::COLOR_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  cad_pkg::cell_t     cell_i,
  output logic               valid_o,
  output cad_pkg::out_item_t item_o
);
  import cad_pkg::*;

  localparam logic [39:0] FS = (40'd1 << COLOR_FRAC_BITS) - 40'd1;
  localparam logic [CW-1:0] MASK = FS[CW-1:0];

  logic               v1_q, v2_q;
  logic [34:0]        sub;
  logic [26:0]        x;
  logic [42:0]        prod;
  logic [17:0]        wq;
  logic [WW-1:0]      w_d, w_q;
  logic [2:0][CW-1:0] c_q, m_d, m_q, o_d, o_q;
  logic [29:0]        mix;

  always_comb begin
    sub  = 35'(35'd100 * {7'd0, cell_i.root});
    x    = 27'(BLEND_TOP - sub);
    prod = {22'd0, x[26:6]} * {21'd0, RECIP_15};
    wq   = prod[RECIP_SHIFT +: 18];
    if (cell_i.tiny || (sub >= BLEND_TOP)) begin
      w_d = '0;
    end else if (wq > {1'b0, W_ONE}) begin
      w_d = W_ONE;
    end else begin
      w_d = wq[WW-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      m_d[i] = cell_i.apply ? cell_i.q[i] : cell_i.c[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mix = 30'({18'd0, c_q[i]} * {13'd0, W_ONE - w_q}) + 30'({18'd0, m_q[i]} * {13'd0, w_q})
            + 30'd32768;
      o_d[i] = mix[16 +: CW] & MASK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q <= w_d;
      c_q <= cell_i.c;
      m_q <= m_d;
      o_q <= o_d;
    end
  end

  assign valid_o          = v2_q;
  assign item_o.red_out   = o_q[0];
  assign item_o.green_out = o_q[1];
  assign item_o.blue_out  = o_q[2];

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the gray stroke darkener. A queued driver and a
// clocked monitor move items under random idling; a behavioural predictor
// computes each expected colour, which the monitor compares field by field.
// ----------------------------------------------------------------------------
module tb;
  import cad_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cad_stream_if #(.T(in_item_t))  item_ch ();
  cad_stream_if #(.T(out_item_t)) result_ch ();

  cad_gray_stroke_darkener_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_ch),
    .result_o(result_ch)
  );

  always #6 clk_i = ~clk_i;

  in_item_t  pending_colours[$];
  out_item_t expected_colours[$];
  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 49;
  bit          hold_sender = 1'b0;
  int unsigned errors = 0;
  longint unsigned cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      b = r | (64'd1 << i);
      if (b * b <= v) r = b;
    end
    return r;
  endfunction

  function automatic longint unsigned abs_entry(logic signed [MW-1:0] x);
    longint signed s;
    s = x;
    return (s < 0) ? -s : s;
  endfunction

  function automatic out_item_t darken_colour(in_item_t it);
    longint unsigned c[3], m[3], mx, mn, lum, fs, t32, l32, ma, mb, s, e, w, top;
    out_item_t r;
    fs = 4095;
    c[0] = 64'(it.red_in); c[1] = 64'(it.green_in); c[2] = 64'(it.blue_in);
    m = c;
    mx = c[0]; mn = c[0];
    for (int i = 1; i < 3; i++) begin
      if (c[i] > mx) mx = c[i];
      if (c[i] < mn) mn = c[i];
    end
    lum = 2126 * c[0] + 7152 * c[1] + 722 * c[2];
    if (100 * (mx - mn) <= 14 * fs && lum <= 8600 * fs && lum > 5000 * fs) begin
      t32 = 48000 * fs + 21 * (lum - 5000 * fs);
      l32 = 32 * lum;
      if (t32 > 115200 * fs) t32 = 115200 * fs;
      if (t32 < l32) begin
        for (int i = 0; i < 3; i++) m[i] = (c[i] * t32 + l32 / 2) / l32;
      end
    end
    ma = abs_entry(it.matrix_a);
    mb = abs_entry(it.matrix_b);
    s = ma * ma + mb * mb;
    top = 64'd84 << 20;
    w = 0;
    if (s > 16) begin
      e = int_sqrt(s << 16);
      if (100 * e < top) begin
        w = (top - 100 * e) / 960;
        if (w > 65536) w = 65536;
      end
    end
    r.red_out   = CW'((c[0] * (65536 - w) + m[0] * w + 32768) >> 16);
    r.green_out = CW'((c[1] * (65536 - w) + m[1] * w + 32768) >> 16);
    r.blue_out  = CW'((c[2] * (65536 - w) + m[2] * w + 32768) >> 16);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_ch.valid <= 1'b0;
      item_ch.data  <= '0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        expected_colours.push_back(darken_colour(item_ch.data));
      end
      if ((!item_ch.valid || item_ch.ready)) begin
        if (pending_colours.size() > 0 && !hold_sender &&
            $urandom_range(99, 0) >= send_idle_pct) begin
          item_ch.valid <= 1'b1;
          item_ch.data  <= pending_colours.pop_front();
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
    end else begin
      cycles <= cycles + 1;
      if (result_ch.valid && result_ch.ready) begin
        if (expected_colours.size() == 0) begin
          $error("Unexpected result item %h", result_ch.data);
          errors++;
        end else begin
          want = expected_colours.pop_front();
          if (result_ch.data.red_out !== want.red_out) begin
            $error("red_out expected %0d actual %0d", want.red_out, result_ch.data.red_out);
            errors++;
          end
          if (result_ch.data.green_out !== want.green_out) begin
            $error("green_out expected %0d actual %0d", want.green_out,
                   result_ch.data.green_out);
            errors++;
          end
          if (result_ch.data.blue_out !== want.blue_out) begin
            $error("blue_out expected %0d actual %0d", want.blue_out,
                   result_ch.data.blue_out);
            errors++;
          end
        end
      end
      result_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  function automatic in_item_t colour_item(int r, int g, int b, int a, int bb);
    in_item_t it;
    it.red_in = CW'(r); it.green_in = CW'(g); it.blue_in = CW'(b);
    it.matrix_a = MW'(a); it.matrix_b = MW'(bb);
    return it;
  endfunction

  function automatic int random_entry();
    case ($urandom_range(4, 0))
      0: return $urandom_range(8, 0) - 4;
      1: return $urandom_range(4096, 0);
      2: return -$urandom_range(4096, 0);
      3: return $urandom_range(3000, 0) - 1500;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t random_colour();
    int base, spread;
    if ($urandom_range(99, 0) < 70) begin
      base = $urandom_range(3600, 1900);
      spread = $urandom_range(600, 0);
      return colour_item(base + $urandom_range(spread, 0) - spread / 2 & 12'hfff,
                         base + $urandom_range(spread, 0) - spread / 2 & 12'hfff,
                         base + $urandom_range(spread, 0) - spread / 2 & 12'hfff,
                         random_entry(), random_entry());
    end
    return colour_item($urandom, $urandom, $urandom, random_entry(), random_entry());
  endfunction

  always @(posedge clk_i) begin
    if (cycles > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    result_ch.ready = 1'b0;
    pending_colours.push_back(colour_item(0, 0, 0, 0, 0));
    pending_colours.push_back(colour_item(4095, 4095, 4095, 4096, 0));
    pending_colours.push_back(colour_item(3000, 3000, 3000, 1, -1));
    pending_colours.push_back(colour_item(3000, 3000, 3000, 4, 0));
    pending_colours.push_back(colour_item(3000, 3000, 3000, 5, 0));
    pending_colours.push_back(colour_item(3000, 3000, 3000, 1229, 0));
    pending_colours.push_back(colour_item(3000, 3000, 3000, 0, -3440));
    pending_colours.push_back(colour_item(3000, 3000, 3000, -524288, -524288));
    pending_colours.push_back(colour_item(3000, 3000, 3000, 524287, 524287));
    pending_colours.push_back(colour_item(2048, 2048, 2048, 100, 0));
    pending_colours.push_back(colour_item(2047, 2047, 2047, 100, 0));
    pending_colours.push_back(colour_item(1966, 1966, 1966, 100, 0));
    pending_colours.push_back(colour_item(3522, 3522, 3522, 100, 0));
    pending_colours.push_back(colour_item(3523, 3523, 3523, 100, 0));
    pending_colours.push_back(colour_item(3300, 3300, 3300, 300, 200));
    pending_colours.push_back(colour_item(3000, 3300, 2800, 0, 50));
    pending_colours.push_back(colour_item(3000, 3574, 3000, 0, 50));
    pending_colours.push_back(colour_item(3000, 3575, 3000, 0, 50));
    pending_colours.push_back(colour_item(4095, 0, 4095, 0, 50));
    pending_colours.push_back(colour_item(2900, 2900, 2900, -2000, 1000));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 600; i++) pending_colours.push_back(random_colour());
    wait (pending_colours.size() == 0);
    hold_sender = 1'b1;
    wait (expected_colours.size() == 0 && !item_ch.valid);
    repeat (40) @(posedge clk_i);
    send_idle_pct = 49;
    recv_idle_pct = 12;
    hold_sender = 1'b0;
    for (int i = 0; i < 650; i++) pending_colours.push_back(random_colour());
    wait (pending_colours.size() == 0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 650; i++) pending_colours.push_back(random_colour());
    wait (pending_colours.size() == 0);
    @(posedge clk_i);
    wait (!item_ch.valid && expected_colours.size() == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/cad_pkg.sv
hdl/cad_stream_if.sv
hdl/cad_front.sv
hdl/cad_cell.sv
hdl/cad_blend.sv
hdl/cad_gray_stroke_darkener_top.sv
sim/tb.sv
